/* design/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks an implication property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/stap_pkg.sv */
`timescale 1ns / 1ps

package stap_pkg;

   // Sample and table sizes.
   localparam int SAMPLE_BITS      = 16;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);

   // Q1.15 unity and quarter turn in Q30.
   localparam logic [16:0] Q15_ONE     = 17'd32768;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Shared multiplier operand and product widths.
   localparam int MUL_W  = ((SAMPLE_BITS > 17) ? SAMPLE_BITS : 17) + 1;
   localparam int PROD_W = 2 * MUL_W;

   // Rounding offset and saturation limits on the rounded product.
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(16384);
   localparam logic signed [PROD_W-1:0] SAT_MAX =
      PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [PROD_W-1:0] SAT_MIN = -SAT_MAX - PROD_W'(1);

   // Register reset values.
   localparam logic [30:0] PHASE_STEP_RESET = 31'd187905;
   localparam logic [15:0] MIX_LEVEL_RESET  = 16'd32768;

   // Register indexes, taken from the word address.
   localparam logic CSR_PHASE_STEP = 1'b0;
   localparam logic CSR_MIX_LEVEL  = 1'b1;

   typedef logic [15:0] sine_rom_type [0:SINE_TABLE_DEPTH-1];

   // Quarter-wave sine table in Q1.15, from a Taylor series evaluated in Q30.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  q;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         sum  = x;
         term = ((x * x2) >> 30) / 6;
         sum  = (sum > term) ? sum - term : 64'd0;
         term = ((term * x2) >> 30) / 20;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 42;
         sum  = (sum > term) ? sum - term : 64'd0;
         term = ((term * x2) >> 30) / 72;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 110;
         sum  = (sum > term) ? sum - term : 64'd0;
         q    = (sum + 64'd16384) >> 15;
         if (q > 64'(Q15_ONE)) begin
            q = 64'(Q15_ONE);
         end
         rom[k] = q[15:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

/* design/stereo_tremolo_autopan.sv */
`timescale 1ns / 1ps
// Stereo tremolo and auto-pan. Each transfer on the req_ channel carries one
// stereo frame; the rsp_ channel returns the two scaled, saturated samples.
// Per frame the 32-bit LFO phase advances by phase_step, |sin(phase)| is read
// from a quarter-wave table and scaled by mix_level; the left sample takes
// gain p + 1 - mix and the right sample (1 - p) + 1 - mix.
// One signed multiplier is shared over three steps under a small sequencer:
// depth scaling, left gain, right gain. A frame is taken in the idle cycle,
// where the phase update and table read happen, and req_tready stays low
// through the three multiply steps. The result is registered in the output
// register at the end of the right-gain step; no new frame is taken until
// the last one is done. If the receiver stalls, the block finishes the next
// frame and then waits with it until the register drains. Reset clears the
// phase, the sequencer and the output valid, and loads phase_step = 187905
// and mix_level = 32768. Registers are written over the csr_ port
// (phase_step at 0x0, mix_level at 0x4) by the user only while the block is
// idle; the block itself does not enforce this.
`include "assert_macros.svh"

module stereo_tremolo_autopan (
   input  logic                          clock,
   input  logic                          reset,
   // Input frame stream.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [2*stap_pkg::SAMPLE_BITS-1:0] req_tdata,  // left_sample, right_sample
   // Result stream.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [2*stap_pkg::SAMPLE_BITS-1:0] rsp_tdata,  // left_out, right_out
   // Register port.
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_LEFT,
      ST_RIGHT
   } state_type;

   state_type state_ff, state_in;

   logic [30:0] step_ff;
   logic [15:0] mix_ff;
   logic [31:0] phase_ff, phase_in;

   logic signed [stap_pkg::SAMPLE_BITS-1:0] xl_ff, xr_ff;
   logic [15:0] sine_ff, sine_in;
   logic [16:0] p_ff;
   logic signed [stap_pkg::SAMPLE_BITS-1:0] left_ff;
   logic signed [stap_pkg::SAMPLE_BITS-1:0] sat_in;

   logic rsp_tvalid_ff;
   logic [stap_pkg::SAMPLE_BITS-1:0] rsp_left_ff, rsp_right_ff;

   logic req_fire, csr_write, out_free;

   logic [16:0] mix_eff;
   logic [16:0] gain_left, gain_right;

   logic [stap_pkg::SINE_IDX_BITS-1:0] idx_raw;
   logic [stap_pkg::SINE_IDX_BITS:0]   idx_fold;

   logic signed [stap_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [stap_pkg::PROD_W-1:0] mul_prod, mul_round;

   // Handshakes.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_right_ff, rsp_left_ff};

   // Register read back.
   always_comb begin
      unique case (csr_paddr[2])
         stap_pkg::CSR_PHASE_STEP: csr_prdata = {1'b0, step_ff};
         stap_pkg::CSR_MIX_LEVEL:  csr_prdata = {16'd0, mix_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // Depth is limited to unity.
   assign mix_eff = (17'(mix_ff) > stap_pkg::Q15_ONE) ? stap_pkg::Q15_ONE : 17'(mix_ff);

   // Phase advance and |sin| lookup for the frame being taken.
   assign phase_in = phase_ff + {1'b0, step_ff};
   assign idx_raw  = phase_in[29 -: stap_pkg::SINE_IDX_BITS];

   always_comb begin
      if (phase_in[30]) begin
         idx_fold = (stap_pkg::SINE_IDX_BITS+1)'(stap_pkg::SINE_TABLE_DEPTH) - {1'b0, idx_raw};
      end else begin
         idx_fold = {1'b0, idx_raw};
      end
      if (idx_fold[stap_pkg::SINE_IDX_BITS]) begin
         sine_in = stap_pkg::Q15_ONE[15:0];
      end else begin
         sine_in = stap_pkg::SINE_ROM[idx_fold[stap_pkg::SINE_IDX_BITS-1:0]];
      end
   end

   // Left and right gains in Q2.15.
   assign gain_left  = p_ff + (stap_pkg::Q15_ONE - mix_eff);
   assign gain_right = (stap_pkg::Q15_ONE - p_ff) + (stap_pkg::Q15_ONE - mix_eff);

   // Shared multiplier operand selection.
   always_comb begin
      unique case (state_ff)
         ST_MIX: begin
            mul_a = stap_pkg::MUL_W'({1'b0, sine_ff});
            mul_b = stap_pkg::MUL_W'(mix_eff);
         end
         ST_LEFT: begin
            mul_a = stap_pkg::MUL_W'(xl_ff);
            mul_b = stap_pkg::MUL_W'(gain_left);
         end
         ST_RIGHT: begin
            mul_a = stap_pkg::MUL_W'(xr_ff);
            mul_b = stap_pkg::MUL_W'(gain_right);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Multiply, round half up and saturate.
   assign mul_prod  = mul_a * mul_b;
   assign mul_round = (mul_prod + stap_pkg::ROUND_HALF) >>> 15;

   always_comb begin
      if (mul_round > stap_pkg::SAT_MAX) begin
         sat_in = stap_pkg::SAT_MAX[stap_pkg::SAMPLE_BITS-1:0];
      end else if (mul_round < stap_pkg::SAT_MIN) begin
         sat_in = stap_pkg::SAT_MIN[stap_pkg::SAMPLE_BITS-1:0];
      end else begin
         sat_in = mul_round[stap_pkg::SAMPLE_BITS-1:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_MIX;
         ST_MIX:   state_in = ST_LEFT;
         ST_LEFT:  state_in = ST_RIGHT;
         ST_RIGHT: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State, registers and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= 32'd0;
         step_ff       <= stap_pkg::PHASE_STEP_RESET;
         mix_ff        <= stap_pkg::MIX_LEVEL_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_paddr[2])
               stap_pkg::CSR_PHASE_STEP: step_ff <= csr_pwdata[30:0];
               stap_pkg::CSR_MIX_LEVEL:  mix_ff  <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            phase_ff <= phase_in;
         end
         if (state_ff == ST_RIGHT && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         xl_ff   <= req_tdata[stap_pkg::SAMPLE_BITS-1:0];
         xr_ff   <= req_tdata[2*stap_pkg::SAMPLE_BITS-1:stap_pkg::SAMPLE_BITS];
         sine_ff <= sine_in;
      end
      if (state_ff == ST_MIX) begin
         p_ff <= mul_round[16:0];
      end
      if (state_ff == ST_LEFT) begin
         left_ff <= sat_in;
      end
      if (state_ff == ST_RIGHT && out_free) begin
         rsp_left_ff  <= left_ff;
         rsp_right_ff <= sat_in;
      end
   end

   // A frame blocks the input for the cycles that follow its transfer.
   `ASSERT_CLK(a_busy_after_take, clock, reset,
      req_tvalid && req_tready |=> !req_tready, "input taken while busy")

   // The phase moves by exactly one step per frame.
   `ASSERT_CLK(a_phase_step, clock, reset,
      req_tvalid && req_tready |=> phase_ff == $past(phase_ff) + 32'($past(step_ff)),
      "phase did not advance by one step")

   // A fresh result traces back to its input transfer through the MIX, LEFT and RIGHT steps.
   `ASSERT_CLK(a_result_timing, clock, reset,
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 4),
      "result valid without a matching frame")

endmodule

/* test/stereo_tremolo_autopan_checker.sv */
`timescale 1ns / 1ps

// Watches the frame, result and register channels of the tremolo block. It keeps its own
// copy of the LFO phase and the two registers, predicts each result frame at the input
// transfer and compares it with the result transfers in order.
module stereo_tremolo_autopan_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,    // left_sample, right_sample
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,    // left_out, right_out
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          pending_count,
   output int          result_count
);

   localparam int     LUT_DEPTH  = stap_pkg::SINE_TABLE_DEPTH;
   localparam longint SAMPLE_MAX = (64'sd1 <<< (stap_pkg::SAMPLE_BITS - 1)) - 64'sd1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 64'sd1;

   // One stereo frame, left channel in the low half.
   typedef struct packed {
      logic signed [15:0] right;
      logic signed [15:0] left;
   } frame_type;

   logic [15:0] sine_lut [0:LUT_DEPTH];
   logic [31:0] lfo_acc;
   logic [30:0] step_reg;
   logic [15:0] depth_reg;
   frame_type   pending_frames [$];

   // Quarter-wave |sin| table in Q1.15 from a Taylor series through x^11 in Q30.
   // The extra entry at the end holds exactly one.
   initial begin : build_lut
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] q;
      for (int k = 0; k <= LUT_DEPTH; k++) begin
         x    = (stap_pkg::HALF_PI_Q30 * k) / LUT_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= 5; n++) begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = (sum > term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         q = (sum + 64'd16384) >> 15;
         if (q > 64'd32768 || k == LUT_DEPTH) begin
            q = 64'd32768;
         end
         sine_lut[k] = q[15:0];
      end
   end

   // Scales a sample by a Q2.15 gain, rounds half up and clamps to the sample range.
   function automatic logic [15:0] scale_sample(input logic signed [15:0] x,
                                                input logic [16:0] gain);
      longint xs;
      longint gs;
      longint acc;
      xs  = x;
      gs  = gain;
      acc = (xs * gs + 64'sd16384) >>> 15;
      if (acc > SAMPLE_MAX) begin
         acc = SAMPLE_MAX;
      end
      if (acc < SAMPLE_MIN) begin
         acc = SAMPLE_MIN;
      end
      return acc[15:0];
   endfunction

   // Expected output frame for an already advanced phase and the current depth.
   function automatic frame_type predict_frame(input logic [31:0] phase,
                                               input logic [15:0] depth,
                                               input frame_type din);
      logic [63:0] pos;
      logic [63:0] idx;
      logic [31:0] sine;
      logic [31:0] depth_sat;
      logic [31:0] swing;
      logic [31:0] gain_l;
      logic [31:0] gain_r;
      frame_type   dout;
      pos = {34'd0, phase[29:0]};
      idx = (pos * LUT_DEPTH) >> 30;
      // Odd quadrants run the table backwards, which folds the wave into |sin|.
      if (phase[30]) begin
         idx = LUT_DEPTH - idx;
      end
      sine      = sine_lut[idx];
      depth_sat = (depth > stap_pkg::Q15_ONE) ? stap_pkg::Q15_ONE : depth;
      swing     = (sine * depth_sat + 32'd16384) >> 15;
      gain_l    = swing + (stap_pkg::Q15_ONE - depth_sat);
      gain_r    = (stap_pkg::Q15_ONE - swing) + (stap_pkg::Q15_ONE - depth_sat);
      dout.left  = scale_sample(din.left, gain_l[16:0]);
      dout.right = scale_sample(din.right, gain_r[16:0]);
      return dout;
   endfunction

   // Register writes, frame predictions and result comparison, all at the rising edge.
   always @(posedge clock) begin
      frame_type got;
      frame_type want;
      if (reset) begin
         pending_frames.delete();
         lfo_acc        = 32'd0;
         step_reg       = stap_pkg::PHASE_STEP_RESET;
         depth_reg      = stap_pkg::MIX_LEVEL_RESET;
         mismatch_count = 0;
         result_count   = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[2])
               stap_pkg::CSR_PHASE_STEP: step_reg  = csr_pwdata[30:0];
               stap_pkg::CSR_MIX_LEVEL:  depth_reg = csr_pwdata[15:0];
               default: ;
            endcase
         end

         // The phase moves before it is used, so the first frame sees one full step.
         if (req_tvalid && req_tready) begin
            lfo_acc = lfo_acc + {1'b0, step_reg};
            pending_frames.push_back(predict_frame(lfo_acc, depth_reg, req_tdata));
         end

         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_frames.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("Unexpected result transfer: left %0d right %0d",
                           got.left, got.right);
               end
               mismatch_count++;
            end else begin
               want = pending_frames.pop_front();
               if (got.left !== want.left || got.right !== want.right) begin
                  if (mismatch_count < 10) begin
                     $display("Result %0d differs: expected left %0d right %0d,",
                              result_count, want.left, want.right,
                              " got left %0d right %0d", got.left, got.right);
                  end
                  mismatch_count++;
               end
            end
            result_count++;
         end
      end
      pending_count = pending_frames.size();
   end

endmodule

/* test/stereo_tremolo_autopan_tb.sv */
`timescale 1ns / 1ps

// Drives stereo frames into the tremolo block with random gaps and output stalls,
// changes both registers between phases, and reports the checker's verdict.
module stereo_tremolo_autopan_tb;

   localparam int HOLD_CYCLES    = 250;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_FRAMES   = 130;

   localparam logic [2:0] ADDR_PHASE_STEP = {stap_pkg::CSR_PHASE_STEP, 2'b00};
   localparam logic [2:0] ADDR_MIX_LEVEL  = {stap_pkg::CSR_MIX_LEVEL, 2'b00};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int pending_count;
   int result_count;
   int frames_sent;
   int settings_count;
   bit idle_enable;
   bit hold_request;

   stereo_tremolo_autopan uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   stereo_tremolo_autopan_checker results_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .result_count   (result_count)
   );

   // 12 ns clock.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Offers one frame, sometimes after an idle burst, and returns at the falling edge
   // after its transfer with tvalid still high.
   task automatic push_frame(input logic [15:0] left, input logic [15:0] right);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      frames_sent++;
   endtask

   // One register write: setup cycle, then access cycle.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Lets every frame in flight come out, then writes both registers.
   task automatic set_config(input logic [30:0] step, input logic [15:0] depth);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_write(ADDR_PHASE_STEP, {1'b0, step});
      csr_write(ADDR_MIX_LEVEL, {16'd0, depth});
      settings_count++;
   endtask

   // Mostly full random samples, with the range ends and zero mixed in.
   function automatic logic [15:0] pick_sample();
      logic [31:0] r;
      r = $urandom;
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: r = 32'h7FFF;
            1: r = 32'h8000;
            2: r = 32'h0000;
            default: r = 32'hFFFF;
         endcase
      end
      return r[15:0];
   endfunction

   // Receiver: random stall bursts, plus one long hold-off when asked for.
   initial begin : sink
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable) || reset) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Watchdog expired with %0d results still expected", pending_count);
      $display("FAIL stereo_tremolo_autopan");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] r;
      logic [30:0] step;
      logic [15:0] depth;
      req_tvalid     = 1'b0;
      req_tdata      = 32'd0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = 3'd0;
      csr_pwdata     = 32'd0;
      reset          = 1'b1;
      frames_sent    = 0;
      settings_count = 0;
      idle_enable    = 1'b1;
      hold_request   = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: the first frame already uses one full phase step.
      push_frame(16'h7FFF, 16'h8000);
      push_frame(16'h8000, 16'h7FFF);
      push_frame(16'h0000, 16'h0000);
      push_frame(16'hFFFF, 16'h0001);

      // Quarter-turn steps visit every quadrant and wrap the phase.
      set_config(31'h4000_0000, 16'd32768);
      push_frame(16'h7FFF, 16'h8000);
      push_frame(16'h8000, 16'h8000);
      push_frame(16'h7FFF, 16'h7FFF);
      push_frame(16'h8000, 16'h7FFF);
      push_frame(16'h1234, 16'hEDCC);

      // Zero depth gives the right channel a gain of two, so it saturates.
      set_config(31'h4000_0000, 16'd0);
      push_frame(16'h7FFF, 16'h7FFF);
      push_frame(16'h8000, 16'h8000);
      push_frame(16'h4000, 16'hC000);

      // Largest step with a depth above one, which is clamped to one.
      set_config(31'h7FFF_FFFF, 16'hFFFF);
      push_frame(16'h7FFF, 16'h8000);
      push_frame(16'h8000, 16'h7FFF);
      push_frame(16'h5555, 16'hAAAA);
      push_frame(16'hAAAA, 16'h5555);

      // A frozen LFO at half depth.
      set_config(31'd0, 16'd16384);
      push_frame(16'h7FFF, 16'h7FFF);
      push_frame(16'h8000, 16'h8000);
      push_frame(16'h0001, 16'hFFFF);

      // Random phases, each with its own step and depth.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         r = $urandom;
         case ($urandom_range(0, 5))
            0: step = 31'd0;
            1: step = 31'h7FFF_FFFF;
            2: step = 31'($urandom_range(1, 1 << 20));
            3: step = 31'h4000_0000 + r[7:0];
            default: step = r[30:0];
         endcase
         r = $urandom;
         case ($urandom_range(0, 4))
            0: depth = 16'd0;
            1: depth = 16'd32768;
            2: depth = 16'($urandom_range(0, 32768));
            3: depth = 16'($urandom_range(32769, 65535));
            default: depth = r[15:0];
         endcase
         if (phase == RANDOM_PHASES - 1) begin
            idle_enable = 1'b0;
         end
         set_config(step, depth);
         // Hold the output off while frames keep coming, so the input backs up.
         if (phase == 3) begin
            hold_request = 1'b1;
         end
         for (int i = 0; i < PHASE_FRAMES; i++) begin
            push_frame(pick_sample(), pick_sample());
         end
      end

      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Covered %0d frames over %0d register settings, both ends of step and depth.",
               frames_sent, settings_count);
      $display("%0d results compared; the output was held off once for %0d cycles.",
               result_count, HOLD_CYCLES);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS stereo_tremolo_autopan");
      end else begin
         $display("FAIL stereo_tremolo_autopan");
      end
      $finish;
   end

endmodule

/* stereo_tremolo_autopan.f */
+incdir+design
design/stap_pkg.sv
design/stereo_tremolo_autopan.sv
test/stereo_tremolo_autopan_checker.sv
test/stereo_tremolo_autopan_tb.sv
